// ===== sv/smpe_pkg.sv =====
// smpe_pkg: shared types and codes of the score map peak extractor
// used by smpe_cfg and score_map_peak_extractor_top; no dependencies

package smpe_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_PICK_MINIMUM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCHES     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_HEIGHT = 3'd5;

    // most peaks per run
    localparam int MAX_RESULTS = 64;
    localparam int MATCH_CNT_W = $clog2(MAX_RESULTS);

    // decoded run settings handed from the register file to the datapath
    typedef struct packed {
        logic                   pick_min;     // 1: smallest score wins
        logic [MATCH_CNT_W-1:0] match_last;   // peaks per run minus one
        logic [CFG_DATA_W-1:0]  map_width;    // raw column count
        logic [CFG_DATA_W-1:0]  map_height;   // raw row count
        logic [7:0]             half_w;       // suppression half width
        logic [7:0]             half_h;       // suppression half height
        logic                   single_peak;  // empty window, stop after first peak
    } smpe_cfg_t;

    // run sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT,
        ST_BOUNDS,
        ST_BASE,
        ST_MARK
    } smpe_state_t;

endpackage

// ===== sv/smpe_cfg.sv =====
// smpe_cfg: configuration registers of the score map peak extractor
// decodes writes and derives run settings; depends on smpe_pkg

module smpe_cfg
    import smpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output smpe_cfg_t             cfg
);

    logic       pick_minimum_reg;
    logic [6:0] max_matches_reg;
    logic [8:0] map_width_reg;
    logic [8:0] map_height_reg;
    logic [8:0] template_width_reg;
    logic [8:0] template_height_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_minimum_reg    <= 1'b1;
            max_matches_reg     <= 7'd1;
            map_width_reg       <= 9'd256;
            map_height_reg      <= 9'd256;
            template_width_reg  <= 9'd1;
            template_height_reg <= 9'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PICK_MINIMUM:    pick_minimum_reg    <= cfg_data[0];
                CFG_MAX_MATCHES:     max_matches_reg     <= cfg_data[6:0];
                CFG_MAP_WIDTH:       map_width_reg       <= cfg_data;
                CFG_MAP_HEIGHT:      map_height_reg      <= cfg_data;
                CFG_TEMPLATE_WIDTH:  template_width_reg  <= cfg_data;
                CFG_TEMPLATE_HEIGHT: template_height_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // derived settings: clamped peak count, half window sizes and single-peak flag
    always_comb
    begin
        cfg.pick_min   = pick_minimum_reg;
        cfg.map_width  = map_width_reg;
        cfg.map_height = map_height_reg;
        cfg.half_w     = template_width_reg[8:1];
        cfg.half_h     = template_height_reg[8:1];
        cfg.single_peak = (template_width_reg[8:1] == 8'd0) ||
                          (template_height_reg[8:1] == 8'd0);
        if (max_matches_reg == 7'd0)
        begin
            cfg.match_last = '0;
        end
        else if (32'(max_matches_reg) > MAX_RESULTS)
        begin
            cfg.match_last = MATCH_CNT_W'(MAX_RESULTS - 1);
        end
        else
        begin
            cfg.match_last = MATCH_CNT_W'(max_matches_reg - 7'd1);
        end
    end

endmodule

// ===== sv/score_map_peak_extractor_top.sv =====
// score_map_peak_extractor_top: score store, suppression overlay and run sequencer
// depends on smpe_pkg and smpe_cfg

// A load word (tuser 0) writes one score into the store in raster order; a run
// word (tuser 1) searches the map and rewinds the load position. Each peak of a
// run costs one scan of the map, a wait state for read latency and compare, an
// emit state that hands the result to the output register (and waits while that
// register still holds an unaccepted word), and, when another peak follows, the
// bounds and base setup states and a mark state that walks the clipped
// suppression window cell by cell; all of it is bound by the single read port of
// the score memory and the single write port of the suppression memory. The
// suppression overlay is cleared while the first scan of a run reads the map, so
// no clearing pass follows reset. Load words are accepted while a final result
// still waits in the output register.

module score_map_peak_extractor_top
    import smpe_pkg::*;
#(
    parameter int MAX_MAP_WIDTH  = 256,
    parameter int MAX_MAP_HEIGHT = 256,
    parameter int SCORE_BITS     = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] score_in
    input  logic [0:0]            s_tuser,   // [0] kind
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // [7:0] match_x, [15:8] match_y,
                                             // [47:16] match_score
    output logic                  m_tlast,   // last
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = $clog2(MAX_MAP_WIDTH + 1);
    localparam int YW    = $clog2(MAX_MAP_HEIGHT + 1);
    localparam int DW0   = (XW > YW) ? XW : YW;
    localparam int DW    = ((DW0 > 8) ? DW0 : 8) + 1;
    localparam int LW    = (SCORE_BITS > 32) ? SCORE_BITS : 32;

    localparam logic signed [SCORE_BITS-1:0] FMT_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [SCORE_BITS-1:0] FMT_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam logic signed [LW-1:0] FMT_MAX_L = LW'(FMT_MAX);
    localparam logic signed [LW-1:0] FMT_MIN_L = LW'(FMT_MIN);
    localparam logic signed [LW-1:0] OUT_MAX_L = LW'(32'sh7FFF_FFFF);
    localparam logic signed [LW-1:0] OUT_MIN_L = LW'(32'sh8000_0000);

    smpe_cfg_t cfg;

    smpe_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // memories
    logic signed [SCORE_BITS-1:0] score_mem [DEPTH];
    logic                         supp_mem  [DEPTH];

    // control state
    smpe_state_t            state_reg, state_next;
    logic [AW-1:0]          load_pos_reg, load_pos_next;
    logic [MATCH_CNT_W-1:0] k_reg, k_next;
    logic                   first_pass_reg, first_pass_next;
    logic [XW-1:0]          ix_reg, ix_next;
    logic [YW-1:0]          iy_reg, iy_next;
    logic [AW-1:0]          scan_addr_reg, scan_addr_next;
    logic                   rd_valid_reg;
    logic                   m_valid_reg, m_valid_next;

    // read stage and running best
    logic                         rd_first_reg;
    logic                         rd_mask_reg;
    logic [XW-1:0]                rd_x_reg;
    logic [YW-1:0]                rd_y_reg;
    logic signed [SCORE_BITS-1:0] score_rdata_reg;
    logic                         supp_rdata_reg;
    logic signed [SCORE_BITS-1:0] best_reg;
    logic [XW-1:0]                bx_reg;
    logic [YW-1:0]                by_reg;

    // suppression window walk
    logic [XW-1:0] xs_reg, xe_reg, mx_reg, mx_next;
    logic [YW-1:0] ys_reg, ye_reg, my_reg, my_next;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic [AW-1:0] mark_addr_reg, mark_addr_next;

    // output payload
    logic [7:0]  out_x_reg;
    logic [7:0]  out_y_reg;
    logic [31:0] out_score_reg;
    logic        out_last_reg;

    // strobes
    logic                  load_we;
    logic                  rd_en;
    logic                  supp_we;
    logic                  supp_wdata;
    logic [AW-1:0]         supp_waddr;
    logic                  out_load;
    logic                  out_last_c;
    logic                  bounds_en;
    logic                  base_en;

    // clamped map size
    logic [XW-1:0] w_c;
    logic [YW-1:0] h_c;

    always_comb
    begin
        if (cfg.map_width == '0)
            w_c = XW'(1);
        else if (32'(cfg.map_width) > MAX_MAP_WIDTH)
            w_c = XW'(MAX_MAP_WIDTH);
        else
            w_c = XW'(cfg.map_width);
        if (cfg.map_height == '0)
            h_c = YW'(1);
        else if (32'(cfg.map_height) > MAX_MAP_HEIGHT)
            h_c = YW'(MAX_MAP_HEIGHT);
        else
            h_c = YW'(cfg.map_height);
    end

    // input score saturated to the store format
    logic signed [LW-1:0]         in_l;
    logic signed [SCORE_BITS-1:0] load_val;

    always_comb
    begin
        in_l = LW'($signed(s_tdata[31:0]));
        if (in_l > FMT_MAX_L)
            load_val = FMT_MAX;
        else if (in_l < FMT_MIN_L)
            load_val = FMT_MIN;
        else
            load_val = SCORE_BITS'(in_l);
    end

    // cell value with the overlay applied, and the compare
    logic signed [SCORE_BITS-1:0] cell_v;
    logic                         better;

    always_comb
    begin
        if (!rd_mask_reg && supp_rdata_reg)
            cell_v = cfg.pick_min ? FMT_MAX : FMT_MIN;
        else
            cell_v = score_rdata_reg;
        better = cfg.pick_min ? (cell_v < best_reg) : (cell_v > best_reg);
    end

    // peak score saturated to the 32-bit result field
    logic signed [LW-1:0] best_l;
    logic [31:0]          best_out;

    always_comb
    begin
        best_l = LW'(best_reg);
        if (best_l > OUT_MAX_L)
            best_out = 32'(OUT_MAX_L);
        else if (best_l < OUT_MIN_L)
            best_out = 32'(OUT_MIN_L);
        else
            best_out = 32'(best_l);
    end

    // clipped window around the peak
    logic [DW-1:0] bx_d, by_d, hw_d, hh_d, w_d, h_d;
    logic [DW-1:0] xs_c, xe_sum, xe_c, ys_c, ye_sum, ye_c;

    always_comb
    begin
        bx_d   = DW'(bx_reg);
        by_d   = DW'(by_reg);
        hw_d   = DW'(cfg.half_w);
        hh_d   = DW'(cfg.half_h);
        w_d    = DW'(w_c);
        h_d    = DW'(h_c);
        xs_c   = (bx_d >= hw_d) ? (bx_d - hw_d) : '0;
        ys_c   = (by_d >= hh_d) ? (by_d - hh_d) : '0;
        xe_sum = bx_d + hw_d;
        ye_sum = by_d + hh_d;
        xe_c   = (xe_sum > w_d) ? w_d : xe_sum;
        ye_c   = (ye_sum > h_d) ? h_d : ye_sum;
    end

    // offset of the first window row
    logic [XW+YW-1:0] row_prod;
    assign row_prod = ys_reg * w_c;

    // scan and window counters
    logic [XW:0] ix_inc, mx_inc;
    logic [YW:0] iy_inc, my_inc;
    logic        row_end, col_end, mrow_end, mcol_end;

    always_comb
    begin
        ix_inc   = {1'b0, ix_reg} + 1'b1;
        iy_inc   = {1'b0, iy_reg} + 1'b1;
        mx_inc   = {1'b0, mx_reg} + 1'b1;
        my_inc   = {1'b0, my_reg} + 1'b1;
        row_end  = (ix_inc == {1'b0, w_c});
        col_end  = (iy_inc == {1'b0, h_c});
        mcol_end = (mx_inc == {1'b0, xe_reg});
        mrow_end = (my_inc == {1'b0, ye_reg});
        out_last_c = (k_reg == cfg.match_last) || cfg.single_peak;
    end

    // sequencer: next state and strobes
    always_comb
    begin
        state_next      = state_reg;
        load_pos_next   = load_pos_reg;
        k_next          = k_reg;
        first_pass_next = first_pass_reg;
        ix_next         = ix_reg;
        iy_next         = iy_reg;
        scan_addr_next  = scan_addr_reg;
        mx_next         = mx_reg;
        my_next         = my_reg;
        row_base_next   = row_base_reg;
        mark_addr_next  = mark_addr_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        s_tready        = 1'b0;
        load_we         = 1'b0;
        rd_en           = 1'b0;
        supp_we         = 1'b0;
        supp_wdata      = 1'b0;
        supp_waddr      = scan_addr_reg;
        out_load        = 1'b0;
        bounds_en       = 1'b0;
        base_en         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!s_tuser[0])
                    begin
                        // store one score, wrap at the end of the store
                        load_we = 1'b1;
                        if (load_pos_reg == AW'(DEPTH - 1))
                            load_pos_next = '0;
                        else
                            load_pos_next = load_pos_reg + 1'b1;
                    end
                    else
                    begin
                        load_pos_next   = '0;
                        k_next          = '0;
                        first_pass_next = 1'b1;
                        ix_next         = '0;
                        iy_next         = '0;
                        scan_addr_next  = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // one cell read per cycle, first pass also clears the overlay
                rd_en      = 1'b1;
                supp_we    = first_pass_reg;
                supp_wdata = 1'b0;
                supp_waddr = scan_addr_reg;
                scan_addr_next = scan_addr_reg + 1'b1;
                if (row_end)
                begin
                    ix_next = '0;
                    iy_next = YW'(iy_inc);
                    if (col_end)
                        state_next = ST_WAIT;
                end
                else
                begin
                    ix_next = XW'(ix_inc);
                end
            end

            ST_WAIT:
            begin
                // last cell compares in this cycle
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = out_last_c ? ST_IDLE : ST_BOUNDS;
                end
            end

            ST_BOUNDS:
            begin
                bounds_en  = 1'b1;
                state_next = ST_BASE;
            end

            ST_BASE:
            begin
                base_en        = 1'b1;
                row_base_next  = AW'(row_prod) + AW'(xs_reg);
                mark_addr_next = AW'(row_prod) + AW'(xs_reg);
                mx_next        = xs_reg;
                my_next        = ys_reg;
                state_next     = ST_MARK;
            end

            ST_MARK:
            begin
                // one window cell marked per cycle
                supp_we    = 1'b1;
                supp_wdata = 1'b1;
                supp_waddr = mark_addr_reg;
                if (mcol_end)
                begin
                    if (mrow_end)
                    begin
                        k_next          = k_reg + 1'b1;
                        first_pass_next = 1'b0;
                        ix_next         = '0;
                        iy_next         = '0;
                        scan_addr_next  = '0;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        mx_next        = xs_reg;
                        my_next        = YW'(my_inc);
                        row_base_next  = row_base_reg + AW'(w_c);
                        mark_addr_next = row_base_reg + AW'(w_c);
                    end
                end
                else
                begin
                    mx_next        = XW'(mx_inc);
                    mark_addr_next = mark_addr_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_pos_reg   <= '0;
            k_reg          <= '0;
            first_pass_reg <= 1'b0;
            ix_reg         <= '0;
            iy_reg         <= '0;
            scan_addr_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_pos_reg   <= load_pos_next;
            k_reg          <= k_next;
            first_pass_reg <= first_pass_next;
            ix_reg         <= ix_next;
            iy_reg         <= iy_next;
            scan_addr_reg  <= scan_addr_next;
            rd_valid_reg   <= rd_en;
            m_valid_reg    <= m_valid_next;
        end
    end

    // score memory: load writes, scan reads
    always_ff @(posedge clk)
    begin
        if (load_we)
            score_mem[load_pos_reg] <= load_val;
        if (rd_en)
            score_rdata_reg <= score_mem[scan_addr_reg];
    end

    // suppression memory: cleared on the first scan, marked per window
    always_ff @(posedge clk)
    begin
        if (supp_we)
            supp_mem[supp_waddr] <= supp_wdata;
        if (rd_en)
            supp_rdata_reg <= supp_mem[scan_addr_reg];
    end

    // read stage tags and running best
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_first_reg <= (scan_addr_reg == '0);
            rd_mask_reg  <= first_pass_reg;
            rd_x_reg     <= ix_reg;
            rd_y_reg     <= iy_reg;
        end
        if (rd_valid_reg && (rd_first_reg || better))
        begin
            best_reg <= cell_v;
            bx_reg   <= rd_x_reg;
            by_reg   <= rd_y_reg;
        end
    end

    // window bounds and walk position
    always_ff @(posedge clk)
    begin
        if (bounds_en)
        begin
            xs_reg <= XW'(xs_c);
            xe_reg <= XW'(xe_c);
            ys_reg <= YW'(ys_c);
            ye_reg <= YW'(ye_c);
        end
        if (base_en || (state_reg == ST_MARK))
        begin
            mx_reg        <= mx_next;
            my_reg        <= my_next;
            row_base_reg  <= row_base_next;
            mark_addr_reg <= mark_addr_next;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg     <= 8'(bx_reg);
            out_y_reg     <= 8'(by_reg);
            out_score_reg <= best_out;
            out_last_reg  <= out_last_c;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_score_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

endmodule
